@@ rtl/core/kvc_pkg.sv @@
// shared types and constants for the associative key/value cache
// used by the cache core, its entry ram and the testbench
package kvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int POL_W = 2;
  localparam int CAP_W = 5;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [POL_W-1:0] POL_NONE = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU  = 2'd1;
  localparam logic [POL_W-1:0] POL_FIFO = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index, taken from paddr[2]
  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    FUNC_PROBE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_INSERT = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FETCH,
    ST_MODIFY,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] rstamp;
    logic [63:0] astamp;
  } entry_t;

endpackage

@@ rtl/core/kvc_ram.sv @@
// entry store: one record (key, value, both stamps) per slot
// single write port, one registered read port; depends on kvc_pkg
module kvc_ram (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [kvc_pkg::IDX_W-1:0] rd_addr,
  output kvc_pkg::entry_t         rd_data,
  input  logic                    wr_en,
  input  logic [kvc_pkg::IDX_W-1:0] wr_addr,
  input  kvc_pkg::entry_t         wr_data
);
  import kvc_pkg::*;

  entry_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/assoc_kv_cache_lru_fifo_core.sv @@
// fully associative key/value cache with none / lru / fifo replacement
// control sequencer and config registers; depends on kvc_pkg and kvc_ram
//
// requests enter on s_* (s_tuser = func, s_tdata = key then value) and one
// result per request leaves on m_* (m_tuser = hit, m_tdata = data, lookups,
// hits). config registers sit on the apb port: policy at 0, capacity at 4;
// writing capacity empties the table. config must be written only while
// idle; the block itself does not enforce it. each request scans the
// filled slots of the entry ram, one slot a cycle through its single read
// port, then may re-read one slot and write it back: after the scan, decide
// (then fetch and modify on a read hit, lru probe hit or active insert with
// nonzero capacity) and resp, which raises m_tvalid as the sequencer goes
// back to idle to take the next request; one request is worked on at a time.
// the result sits in an output register: while the receiver stalls the next
// request is still taken and worked on, and only its final step waits for
// the output register to free up.
// reset (synchronous) clears the fill count, stamp clocks, counters and the
// registers (policy none, capacity 16); the entry ram itself is not cleared.
module assoc_kv_cache_lru_fifo_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // key [63:0], value [127:64]
  input  logic [1:0]   s_tuser,   // func [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // data [63:0], lookups [127:64], hits [191:128]
  output logic [0:0]   m_tuser,   // hit [0]
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import kvc_pkg::*;

  state_t state, state_next;

  logic [POL_W-1:0] policy;
  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] fill_count;
  logic [63:0]      rclock;
  logic [63:0]      aclock;
  logic [63:0]      lookup_count;
  logic [63:0]      hit_count;

  // current request
  logic [1:0]  op_func;
  logic [63:0] op_key;
  logic [63:0] op_value;

  // scan results
  logic [CNT_W-1:0] iss;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             found;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] min_idx;
  logic [63:0]      min_stamp;
  logic [IDX_W-1:0] tgt_idx;
  logic             res_hit;
  logic [63:0]      res_data;

  // output register
  logic        out_hit;
  logic [63:0] out_data;
  logic [63:0] out_lookups;
  logic [63:0] out_hits;

  // ram ports
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  entry_t           ram_rd_data;
  logic             ram_wr_en;
  entry_t           ram_wr_data;

  logic in_acc;
  logic cfg_wr;
  logic active;
  logic lru;
  logic [CMP_W-1:0] eff_cap;
  logic room;
  logic issue;
  logic [63:0] rd_stamp;
  logic need_fetch;
  logic grow;
  logic [IDX_W-1:0] tgt_sel;
  logic out_free;

  assign in_acc   = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity}
                                               : {{(32-POL_W){1'b0}}, policy};
  assign active   = (policy == POL_LRU) || (policy == POL_FIFO);
  assign lru      = (policy == POL_LRU);
  assign eff_cap  = (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
                                                            : CMP_W'(capacity);
  assign room     = CMP_W'(fill_count) < eff_cap;
  assign issue    = (state == ST_SCAN) && (iss < fill_count);
  assign rd_stamp = lru ? ram_rd_data.rstamp : ram_rd_data.astamp;
  assign out_free = !m_tvalid || m_tready;

  assign m_tdata    = {out_hits, out_lookups, out_data};
  assign m_tuser[0] = out_hit;

  kvc_ram u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (tgt_idx),
    .wr_data (ram_wr_data)
  );

  // what the request does once the scan is over
  always_comb begin
    need_fetch = 1'b0;
    grow       = 1'b0;
    tgt_sel    = match_idx;
    case (op_func)
      FUNC_PROBE:  need_fetch = active && found && lru;
      FUNC_READ:   need_fetch = found;
      FUNC_INSERT: begin
        if (active && (eff_cap != '0)) begin
          need_fetch = 1'b1;
          if (!found) begin
            if (room) begin
              tgt_sel = fill_count[IDX_W-1:0];
              grow    = 1'b1;
            end else begin
              tgt_sel = min_idx;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = tgt_idx;
    ram_wr_en   = 1'b0;
    ram_wr_data = ram_rd_data;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_rd_en   = issue;
        ram_rd_addr = iss[IDX_W-1:0];
        if (!issue && !rd_vld) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = need_fetch ? ST_FETCH : ST_RESP;
      end
      ST_FETCH: begin
        ram_rd_en  = 1'b1;
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        // slot was read back in the previous cycle: patch and write it
        if (op_func == FUNC_PROBE) begin
          ram_wr_en          = 1'b1;
          ram_wr_data.rstamp = rclock;
        end else if (op_func == FUNC_INSERT) begin
          ram_wr_en         = 1'b1;
          ram_wr_data.value = op_value;
          if (!found) begin
            ram_wr_data.key = op_key;
          end
          if (lru) begin
            ram_wr_data.rstamp = rclock;
          end else if (!found) begin
            ram_wr_data.astamp = aclock;
          end
        end
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state, counters, config
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POL_NONE;
      capacity     <= CAP_RESET;
      fill_count   <= '0;
      rclock       <= '0;
      aclock       <= '0;
      lookup_count <= '0;
      hit_count    <= '0;
      rd_vld       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (state == ST_DECIDE) begin
        if (grow) begin
          fill_count <= fill_count + 1'b1;
        end
        if ((op_func == FUNC_PROBE) && active) begin
          lookup_count <= lookup_count + 64'd1;
          if (found) begin
            hit_count <= hit_count + 64'd1;
          end
        end
      end
      if (state == ST_MODIFY) begin
        if ((op_func == FUNC_PROBE) || ((op_func == FUNC_INSERT) && lru)) begin
          rclock <= rclock + 64'd1;
        end
        if ((op_func == FUNC_INSERT) && !lru && !found) begin
          aclock <= aclock + 64'd1;
        end
      end
      if ((state == ST_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_POLICY) begin
          policy <= pwdata[POL_W-1:0];
        end else begin
          capacity   <= pwdata[CAP_W-1:0];
          fill_count <= '0;
        end
      end
    end
  end

  // request payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_func  <= s_tuser;
      op_key   <= s_tdata[63:0];
      op_value <= s_tdata[127:64];
      iss      <= '0;
      found    <= 1'b0;
      res_hit  <= 1'b0;
      res_data <= '0;
    end
    if (issue) begin
      iss    <= iss + 1'b1;
      rd_idx <= iss[IDX_W-1:0];
    end
    if ((state == ST_SCAN) && rd_vld) begin
      // first match wins; lowest index wins on equal stamps
      if (!found && (ram_rd_data.key == op_key)) begin
        found     <= 1'b1;
        match_idx <= rd_idx;
      end
      if ((rd_idx == '0) || (rd_stamp < min_stamp)) begin
        min_stamp <= rd_stamp;
        min_idx   <= rd_idx;
      end
    end
    if (state == ST_DECIDE) begin
      tgt_idx <= tgt_sel;
      case (op_func)
        FUNC_PROBE:  res_hit <= active && found;
        FUNC_READ: begin
          res_hit <= found;
          if (!found) begin
            res_data <= '1;
          end
        end
        FUNC_INSERT: res_hit <= active && (eff_cap != '0) && found;
        default: ;
      endcase
    end
    if ((state == ST_MODIFY) && (op_func == FUNC_READ)) begin
      res_data <= ram_rd_data.value;
    end
    if ((state == ST_RESP) && out_free) begin
      out_hit     <= res_hit;
      out_data    <= res_data;
      out_lookups <= lookup_count;
      out_hits    <= hit_count;
    end
  end

endmodule

@@ rtl/core/kvc_checker.sv @@
// port-level checks for the key/value cache core, bound to the top level
// depends only on the top level's ports
module kvc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata,
  input logic [0:0]   m_tuser
);

  logic        in_acc;
  logic        out_acc;
  logic [1:0]  outstanding;
  logic [63:0] last_lk;
  logic [63:0] last_hk;
  logic [63:0] lk_now;
  logic [63:0] hk_now;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign lk_now  = m_tdata[127:64];
  assign hk_now  = m_tdata[191:128];

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      last_lk     <= '0;
      last_hk     <= '0;
    end else begin
      outstanding <= outstanding + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        last_lk <= lk_now;
        last_hk <= hk_now;
      end
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one request in flight besides the one waiting in the output register
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (outstanding <= 2'd1))
    else $error("request taken with too many in flight");

  // each result moves the lookup count by at most one
  a_lk_step: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (lk_now == last_lk) || (lk_now == last_lk + 64'd1))
    else $error("lookup count jumped");

  // a counted hit is always a counted lookup
  a_hk_step: assert property (@(posedge clk) disable iff (rst)
    out_acc && (hk_now != last_hk) |-> (hk_now == last_hk + 64'd1) && (lk_now != last_lk))
    else $error("hit count moved without a lookup");

endmodule

bind assoc_kv_cache_lru_fifo_core kvc_checker u_kvc_checker (.*);

@@ dv/assoc_kv_cache_lru_fifo_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the associative key/value cache core
// needs kvc_pkg and the core rtl; predicts every response and checks apb read-back

module assoc_kv_cache_lru_fifo_core_tb;
  import kvc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] POL_RSVD = 2'd3;
  localparam logic [2:0] ADDR_POLICY = {REG_POLICY, 2'b00};
  localparam logic [2:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_PHASES = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [63:0] value;
  } kv_req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] data;
    logic [63:0] lookups;
    logic [63:0] hits;
  } kv_resp_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;  // key [63:0], value [127:64]
  logic [1:0]   s_tuser = '0;  // func [1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;       // data [63:0], lookups [127:64], hits [191:128]
  logic [0:0]   m_tuser;       // hit [0]
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  assoc_kv_cache_lru_fifo_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the cache contents and registers
  logic [63:0] sh_keys [MAX_ENTRIES];
  logic [63:0] sh_vals [MAX_ENTRIES];
  logic [63:0] sh_rstamp [MAX_ENTRIES];
  logic [63:0] sh_astamp [MAX_ENTRIES];
  int          sh_fill = 0;
  logic [63:0] sh_rclock = '0;
  logic [63:0] sh_aclock = '0;
  logic [63:0] sh_lookups = '0;
  logic [63:0] sh_hits = '0;
  logic [1:0]  cfg_policy = POL_NONE;
  logic [4:0]  cfg_capacity = CAP_RESET;

  kv_req_t     pending_reqs[$];
  kv_resp_t    expected_responses[$];
  kv_req_t     cur_req;
  kv_resp_t    want;
  int          in_flight = 0;
  int          fail_count = 0;
  int          n_requests = 0;
  int          n_responses = 0;
  int          n_cfg_writes = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;
  logic [63:0] key_pool [32];
  int          pool_len = 1;

  function automatic kv_resp_t predict_cache_response(input kv_req_t r);
    kv_resp_t res;
    logic     active;
    int       slot;
    int       cap;
    int       i;
    logic [63:0] low;
    res = '0;
    active = (cfg_policy == POL_LRU) || (cfg_policy == POL_FIFO);
    slot = -1;
    for (i = 0; i < sh_fill; i++) begin
      if (slot < 0 && sh_keys[i] == r.key) slot = i;
    end
    cap = (cfg_capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_capacity);
    case (r.func)
      FUNC_PROBE: begin
        if (active) begin
          sh_lookups++;
          if (slot >= 0) begin
            res.hit = 1'b1;
            sh_hits++;
            if (cfg_policy == POL_LRU) begin
              sh_rstamp[slot] = sh_rclock;
              sh_rclock++;
            end
          end
        end
      end
      FUNC_READ: begin
        if (slot >= 0) begin
          res.hit = 1'b1;
          res.data = sh_vals[slot];
        end else begin
          res.data = '1;
        end
      end
      FUNC_INSERT: begin
        if (active && cap != 0) begin
          if (slot >= 0) begin
            res.hit = 1'b1;
            sh_vals[slot] = r.value;
            if (cfg_policy == POL_LRU) begin
              sh_rstamp[slot] = sh_rclock;
              sh_rclock++;
            end
          end else begin
            if (sh_fill < cap) begin
              slot = sh_fill;
              sh_fill++;
            end else begin
              // full: victim is the smallest stamp, lowest index on a tie
              slot = 0;
              low = (cfg_policy == POL_LRU) ? sh_rstamp[0] : sh_astamp[0];
              for (i = 1; i < sh_fill; i++) begin
                if (cfg_policy == POL_LRU && sh_rstamp[i] < low) begin
                  low = sh_rstamp[i];
                  slot = i;
                end else if (cfg_policy == POL_FIFO && sh_astamp[i] < low) begin
                  low = sh_astamp[i];
                  slot = i;
                end
              end
            end
            sh_keys[slot] = r.key;
            sh_vals[slot] = r.value;
            if (cfg_policy == POL_LRU) begin
              sh_rstamp[slot] = sh_rclock;
              sh_rclock++;
            end else begin
              sh_astamp[slot] = sh_aclock;
              sh_aclock++;
            end
          end
        end
      end
      default: ;
    endcase
    res.lookups = sh_lookups;
    res.hits = sh_hits;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_responses.push_back(predict_cache_response(cur_req));
        n_requests++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_flight++;
          s_tvalid <= 1'b1;
          s_tdata <= {cur_req.value, cur_req.key};
          s_tuser <= cur_req.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        n_responses++;
        if (in_flight > 0) in_flight--;
        if (expected_responses.size() == 0) begin
          $error("response with no request waiting");
          fail_count++;
        end else begin
          want = expected_responses.pop_front();
          if (m_tuser[0] !== want.hit) begin
            $error("hit: expected %0h, got %0h", want.hit, m_tuser[0]);
            fail_count++;
          end
          if (m_tdata[63:0] !== want.data) begin
            $error("data: expected %0h, got %0h", want.data, m_tdata[63:0]);
            fail_count++;
          end
          if (m_tdata[127:64] !== want.lookups) begin
            $error("lookups: expected %0h, got %0h", want.lookups, m_tdata[127:64]);
            fail_count++;
          end
          if (m_tdata[191:128] !== want.hits) begin
            $error("hits: expected %0h, got %0h", want.hits, m_tdata[191:128]);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
        $display("assoc_kv_cache_lru_fifo_core_tb failed");
        $finish;
      end
    end
  end

  // apb write, then read the register back
  task automatic cfg_write(input logic [2:0] addr, input logic [4:0] val);
    logic [31:0] reg_val;
    reg_val = (addr == ADDR_POLICY) ? {30'b0, val[1:0]} : {27'b0, val};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {27'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_POLICY) begin
      cfg_policy = val[1:0];
    end else begin
      cfg_capacity = val;
      sh_fill = 0;
    end
    n_cfg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata !== reg_val) begin
      $error("prdata: expected %0h, got %0h", reg_val, prdata);
      fail_count++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_req(input logic [1:0] func, input logic [63:0] key,
                          input logic [63:0] value);
    kv_req_t r;
    r.func = func;
    r.key = key;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // mostly keys from the phase pool so hits and evictions happen
  task automatic rand_reqs(input int n);
    int          k;
    int          pick;
    logic [1:0]  func;
    logic [63:0] key;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 38) func = FUNC_INSERT;
      else if (pick < 72) func = FUNC_PROBE;
      else if (pick < 94) func = FUNC_READ;
      else func = FUNC_UNUSED;
      if ($urandom_range(9) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(pool_len - 1)];
      push_req(func, key, {$urandom, $urandom});
    end
  endtask

  task automatic drain;
    while (pending_reqs.size() != 0 || in_flight != 0) @(posedge clk);
  endtask

  initial begin
    int         ph;
    int         i;
    int         pick;
    logic [1:0] pol;
    logic [4:0] cap;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: caching off
    push_req(FUNC_PROBE, 64'h0, 64'h0);
    push_req(FUNC_INSERT, 64'h0, '1);
    push_req(FUNC_READ, 64'h0, 64'h0);
    push_req(FUNC_UNUSED, '1, '1);
    drain();

    // lru with two slots: refresh on probe hit, evict the stale one, update in place
    cfg_write(ADDR_POLICY, 5'(POL_LRU));
    cfg_write(ADDR_CAPACITY, 5'd2);
    push_req(FUNC_INSERT, 64'h0, 64'h1);
    push_req(FUNC_INSERT, '1, 64'h0);
    push_req(FUNC_PROBE, 64'h0, '1);
    push_req(FUNC_INSERT, 64'h0123_4567_89ab_cdef, 64'h5555_aaaa_5555_aaaa);
    push_req(FUNC_READ, '1, 64'h0);
    push_req(FUNC_READ, 64'h0, 64'h0);
    push_req(FUNC_INSERT, 64'h0, '1);
    push_req(FUNC_PROBE, 64'h0123_4567_89ab_cdef, 64'h0);
    push_req(FUNC_UNUSED, 64'h0, 64'h0);
    drain();

    // fifo with two slots: probe hit does not save the oldest entry
    cfg_write(ADDR_POLICY, 5'(POL_FIFO));
    cfg_write(ADDR_CAPACITY, 5'd2);
    push_req(FUNC_INSERT, 64'h8000_0000_0000_0001, 64'haaaa_5555_aaaa_5555);
    push_req(FUNC_INSERT, 64'h7fff_ffff_ffff_fffe, 64'h1234);
    push_req(FUNC_PROBE, 64'h8000_0000_0000_0001, 64'h0);
    push_req(FUNC_INSERT, 64'hdead_beef_0000_0000, 64'h9);
    push_req(FUNC_READ, 64'h8000_0000_0000_0001, 64'h0);
    push_req(FUNC_READ, 64'h7fff_ffff_ffff_fffe, 64'h0);
    drain();

    // zero capacity: inserts dropped, probes still counted
    cfg_write(ADDR_CAPACITY, 5'd0);
    push_req(FUNC_INSERT, 64'h42, 64'h42);
    push_req(FUNC_PROBE, 64'h42, 64'h0);
    push_req(FUNC_READ, 64'h42, 64'h0);
    drain();

    // reserved policy behaves as off; capacity 31, beyond the table, is written and read back
    cfg_write(ADDR_POLICY, 5'(POL_RSVD));
    cfg_write(ADDR_CAPACITY, 5'd31);
    push_req(FUNC_INSERT, 64'h42, 64'h42);
    push_req(FUNC_PROBE, 64'h42, 64'h0);
    push_req(FUNC_READ, 64'h42, 64'h0);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (ph)
        0: begin pol = POL_LRU;  cap = CAP_RESET; end
        1: begin pol = POL_FIFO; cap = 5'd1;  end
        2: begin pol = POL_LRU;  cap = 5'd0;  end
        3: begin pol = POL_FIFO; cap = 5'd31; end
        default: begin
          pick = $urandom_range(99);
          if (pick < 40) pol = POL_LRU;
          else if (pick < 80) pol = POL_FIFO;
          else if (pick < 90) pol = POL_NONE;
          else pol = POL_RSVD;
          pick = $urandom_range(99);
          if (pick < 15) cap = 5'($urandom_range(17, 31));
          else if (pick < 20) cap = 5'd0;
          else cap = 5'($urandom_range(1, MAX_ENTRIES));
        end
      endcase
      // writing capacity empties the table, so stamps never go stale across policies
      cfg_write(ADDR_POLICY, 5'(pol));
      cfg_write(ADDR_CAPACITY, cap);
      pool_len = ((cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap)) + $urandom_range(1, 4);
      for (i = 0; i < pool_len; i++) key_pool[i] = {$urandom, $urandom};
      if (ph % 2 == 0) begin
        key_pool[0] = '0;
        key_pool[pool_len - 1] = '1;
      end
      rand_reqs(85);
      drain();
      // caching off over a filled table, then back on with the same policy
      if ((pol == POL_LRU || pol == POL_FIFO) && $urandom_range(2) == 0) begin
        cfg_write(ADDR_POLICY, 5'(POL_NONE));
        rand_reqs(25);
        drain();
        cfg_write(ADDR_POLICY, 5'(pol));
        rand_reqs(25);
        drain();
      end
    end

    repeat (MAX_ENTRIES + 10) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $error("%0d responses never arrived", expected_responses.size());
      fail_count++;
    end
    $display("ran %0d requests with %0d responses checked over %0d register writes",
             n_requests, n_responses, n_cfg_writes);
    $display("policies off/lru/fifo/reserved, capacities 0 to 31, final lookups %0d hits %0d",
             sh_lookups, sh_hits);
    if (fail_count == 0) begin
      $display("assoc_kv_cache_lru_fifo_core_tb passed");
    end else begin
      $display("assoc_kv_cache_lru_fifo_core_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kvc_pkg.sv
rtl/core/kvc_ram.sv
rtl/core/assoc_kv_cache_lru_fifo_core.sv
rtl/core/kvc_checker.sv
dv/assoc_kv_cache_lru_fifo_core_tb.sv
